### hdl/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types and constants of the line rasterizer: request, pixel and
// job formats, colour codes and back-end states.
// ----------------------------------------------------------------------------
package lrb_pkg;

    // Width of every coordinate field at the ports
    localparam int COORD_W  = 6;
    localparam int COLOUR_W = 8;

    // Algorithm select codes
    localparam logic MODE_BRES = 1'b0;
    localparam logic MODE_DDA  = 1'b1;

    // Colour index per algorithm
    localparam logic [COLOUR_W-1:0] COLOUR_BRES = 8'd5;
    localparam logic [COLOUR_W-1:0] COLOUR_DDA  = 8'd33;

    // Line request
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               mode;
    } req_t;

    // Emitted pixel
    typedef struct packed {
        logic [COORD_W-1:0]  pix_x;
        logic [COORD_W-1:0]  pix_y;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } pix_t;

    // Classified line job handed from front end to back end
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] maj;     // larger delta, also the step count
        logic [COORD_W-1:0] mnr;     // smaller delta
        logic               sx_neg;  // x walks downward
        logic               sy_neg;  // y walks downward
        logic               xmajor;
        logic               mode;
    } job_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } back_state_t;

    // Back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic dividing;
    } back_status_t;

endpackage

### hdl/line_rasterizer_bresenham_dda_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_bresenham_dda_unit
// Line rasterizer: one request in, the pixel run of that line out.
// ----------------------------------------------------------------------------
// Each request (two endpoints and a mode bit) yields max(|dx|,|dy|)+1 pixels,
// the final one flagged with last. Mode 0 draws with the Bresenham error term
// in all octants (colour 5); mode 1 draws with a DDA whose minor-axis
// increment is a truncated fixed-point quotient with FRAC_BITS fractional
// bits (colour 33). A front stage classifies requests into a two-entry job
// queue, so new requests are taken while a line is still drawn. The back end
// emits one pixel per cycle while the output is not stalled: every line starts
// with a load from the queue, and a DDA line of more than one pixel first runs
// the bit-serial restoring divider for its minor-axis increment. Output stalls
// hold the back end.
// ----------------------------------------------------------------------------
module line_rasterizer_bresenham_dda_unit
    import lrb_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic         f_valid, f_ready;
    job_t         f_job;
    logic         q_valid, q_ready;
    job_t         q_job;
    back_status_t b_status;

    // Request classification
    lrb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // Job queue
    lrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    // Line drawing
    lrb_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .status    (b_status)
    );

    // A queued job is picked up as soon as the back end is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && b_status.idle) |=> !b_status.idle)
        else $error("queued job not started by idle back end");

    // A pixel that is not the last leaves the back end still drawing
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix.last) |-> (!b_status.idle && !b_status.dividing))
        else $error("line ended without a last pixel");

    // Colour always matches one of the two algorithms
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (pix.colour == COLOUR_BRES || pix.colour == COLOUR_DDA))
        else $error("unexpected pixel colour");

    // The divider is only ever entered straight from a job load
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_status.dividing && !$past(b_status.dividing)) |-> $past(b_status.idle))
        else $error("divider started outside job load");

endmodule

### hdl/lrb_front.sv
// ----------------------------------------------------------------------------
// lrb_front
// Accepts line requests, works out deltas, directions and the major axis,
// and holds the classified job in a register until the queue takes it.
// ----------------------------------------------------------------------------
module lrb_front
    import lrb_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);

    logic                  valid_reg;
    job_t                  job_reg;
    job_t                  job_next;
    logic [COORD_BITS-1:0] x1, y1, x2, y2, dx, dy;
    logic                  x_dn, y_dn;

    // Upper coordinate bits are ignored
    assign x1 = req.start_x[COORD_BITS-1:0];
    assign y1 = req.start_y[COORD_BITS-1:0];
    assign x2 = req.end_x[COORD_BITS-1:0];
    assign y2 = req.end_y[COORD_BITS-1:0];

    // Classification
    always_comb
    begin
        x_dn = (x2 < x1);
        y_dn = (y2 < y1);
        dx   = x_dn ? (x1 - x2) : (x2 - x1);
        dy   = y_dn ? (y1 - y2) : (y2 - y1);
        job_next.x0     = COORD_W'(x1);
        job_next.y0     = COORD_W'(y1);
        job_next.xmajor = (dx >= dy);
        job_next.maj    = (dx >= dy) ? COORD_W'(dx) : COORD_W'(dy);
        job_next.mnr    = (dx >= dy) ? COORD_W'(dy) : COORD_W'(dx);
        job_next.sx_neg = x_dn;
        job_next.sy_neg = y_dn;
        job_next.mode   = req.mode;
    end

    assign req_ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // Holding register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    // Holding register payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

### hdl/lrb_queue.sv
// ----------------------------------------------------------------------------
// lrb_queue
// Two-entry job queue between front end and back end.
// ----------------------------------------------------------------------------
module lrb_queue
    import lrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### hdl/lrb_back.sv
// ----------------------------------------------------------------------------
// lrb_back
// Draws one queued line: an optional restoring divider for the DDA minor
// increment, then one pixel per cycle into the output register when free.
// ----------------------------------------------------------------------------
module lrb_back
    import lrb_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    output logic         job_ready,
    input  job_t         job,
    output logic         pix_valid,
    input  logic         pix_ready,
    output pix_t         pix,
    output back_status_t status
);

    localparam int C     = COORD_BITS;
    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int INC_W = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [INC_W-1:0] ONE_INC = INC_W'(1) << FRAC_BITS;

    back_state_t              state_reg, state_next;
    logic [C-1:0]             maj_reg, maj_next;
    logic [C-1:0]             x_reg, x_next;
    logic [C-1:0]             y_reg, y_next;
    logic [C-1:0]             steps_reg, steps_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;
    logic                     xmajor_reg, xmajor_next;
    logic                     mode_reg, mode_next;
    logic signed [ERR_W-1:0]  p_reg, p_next;
    logic signed [ERR_W-1:0]  dp_pos_reg, dp_pos_next;
    logic signed [ERR_W-1:0]  dp_neg_reg, dp_neg_next;
    logic [ACC_W-1:0]         acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]         acc_y_reg, acc_y_next;
    logic [INC_W-1:0]         quot_reg, quot_next;
    logic [C:0]               rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    pix_t                     pix_reg, pix_next;

    logic [C-1:0]             jmaj, jmnr;
    logic                     slot_free;
    logic                     rem_ge;
    logic [C:0]               rem_sub;
    logic [ACC_W-1:0]         inc_x, inc_y;
    logic signed [ERR_W-1:0]  twice_mnr, twice_maj;

    assign jmaj      = job.maj[C-1:0];
    assign jmnr      = job.mnr[C-1:0];
    assign twice_mnr = $signed({2'b00, jmnr, 1'b0});
    assign twice_maj = $signed({2'b00, jmaj, 1'b0});
    assign slot_free = !out_valid_reg || pix_ready;
    assign rem_ge    = (rem_reg >= {1'b0, maj_reg});
    assign rem_sub   = rem_reg - {1'b0, maj_reg};

    // Major axis moves one whole pixel, minor axis the divided increment
    assign inc_x = xmajor_reg ? ACC_W'(ONE_INC) : ACC_W'(quot_reg);
    assign inc_y = xmajor_reg ? ACC_W'(quot_reg) : ACC_W'(ONE_INC);

    assign job_ready       = (state_reg == ST_IDLE);
    assign pix_valid       = out_valid_reg;
    assign pix             = pix_reg;
    assign status.idle     = (state_reg == ST_IDLE);
    assign status.dividing = (state_reg == ST_DIV);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        maj_next       = maj_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        steps_next     = steps_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        xmajor_next    = xmajor_reg;
        mode_next      = mode_reg;
        p_next         = p_reg;
        dp_pos_next    = dp_pos_reg;
        dp_neg_next    = dp_neg_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pix_ready;
        pix_next       = pix_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    maj_next    = jmaj;
                    x_next      = job.x0[C-1:0];
                    y_next      = job.y0[C-1:0];
                    steps_next  = jmaj;
                    sx_neg_next = job.sx_neg;
                    sy_neg_next = job.sy_neg;
                    xmajor_next = job.xmajor;
                    mode_next   = job.mode;
                    p_next      = twice_mnr - $signed({3'b000, jmaj});
                    dp_pos_next = twice_mnr - twice_maj;
                    dp_neg_next = twice_mnr;
                    acc_x_next  = {job.x0[C-1:0], {FRAC_BITS{1'b0}}};
                    acc_y_next  = {job.y0[C-1:0], {FRAC_BITS{1'b0}}};
                    quot_next   = '0;
                    rem_next    = {1'b0, jmnr};
                    cnt_next    = CNT_W'(FRAC_BITS);
                    if (job.mode == MODE_DDA && jmaj != '0)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            ST_DIV:
            begin
                // One quotient bit per cycle: (mnr << FRAC_BITS) / maj
                quot_next = {quot_reg[INC_W-2:0], rem_ge};
                rem_next  = rem_ge ? {rem_sub[C-1:0], 1'b0} : {rem_reg[C-1:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pix_next.last  = (steps_reg == '0);
                    if (mode_reg == MODE_DDA)
                    begin
                        pix_next.pix_x  = COORD_W'(acc_x_reg[ACC_W-1:FRAC_BITS]);
                        pix_next.pix_y  = COORD_W'(acc_y_reg[ACC_W-1:FRAC_BITS]);
                        pix_next.colour = COLOUR_DDA;
                    end
                    else
                    begin
                        pix_next.pix_x  = COORD_W'(x_reg);
                        pix_next.pix_y  = COORD_W'(y_reg);
                        pix_next.colour = COLOUR_BRES;
                    end

                    if (steps_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        steps_next = steps_reg - C'(1);
                        // DDA accumulators
                        acc_x_next = sx_neg_reg ? acc_x_reg - inc_x : acc_x_reg + inc_x;
                        acc_y_next = sy_neg_reg ? acc_y_reg - inc_y : acc_y_reg + inc_y;
                        // Bresenham: major axis every step, minor on p >= 0
                        if (p_reg >= 0)
                        begin
                            p_next = p_reg + dp_pos_reg;
                        end
                        else
                        begin
                            p_next = p_reg + dp_neg_reg;
                        end
                        if (xmajor_reg || p_reg >= 0)
                        begin
                            x_next = sx_neg_reg ? x_reg - C'(1) : x_reg + C'(1);
                        end
                        if (!xmajor_reg || p_reg >= 0)
                        begin
                            y_next = sy_neg_reg ? y_reg - C'(1) : y_reg + C'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        maj_reg    <= maj_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        xmajor_reg <= xmajor_next;
        mode_reg   <= mode_next;
        p_reg      <= p_next;
        dp_pos_reg <= dp_pos_next;
        dp_neg_reg <= dp_neg_next;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        pix_reg    <= pix_next;
    end

endmodule

### sim/line_rasterizer_bresenham_dda_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_bresenham_dda_unit_test
// Self-checking bench for the line rasterizer.
// ----------------------------------------------------------------------------
// Line requests go in through a valid/ready channel and the pixel stream is
// taken from a second one. Each accepted untyped request is expanded by an
// in-bench line model (Bresenham over all octants, or a truncating fixed-point
// DDA) into the pixels it must produce. Each pixel transaction is compared
// field by field against the oldest pixel still owed. A short table of
// directed lines runs first, then random lines, with random gaps on both sides
// and one long output stall that backs the block up into its request port.
// ----------------------------------------------------------------------------
module line_rasterizer_bresenham_dda_unit_test;
    import lrb_pkg::*;

    localparam int COORD_BITS   = 6;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = COORD_BITS + FRAC_BITS;
    localparam int RANDOM_LINES = 306;
    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 120;
    localparam int DIR_ROWS     = 24;

    // One directed line; a typed-in pixel is used where the answer is obvious
    typedef struct {
        req_t line;
        bit   typed;
        pix_t pixel;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;

    // Pixels owed by the block, oldest first
    pix_t owed_pixels [$];

    // Line model state
    logic [ACC_W-1:0] dda_acc_x;
    logic [ACC_W-1:0] dda_acc_y;
    logic [6:0]       pixels_left;

    int  mismatch_count;
    int  pixels_checked;
    bit  stimulus_done;
    bit  long_hold_armed;
    int  send_calm;
    int  take_calm;

    dir_row_t directed_lines [DIR_ROWS] = '{
        // single-pixel lines, both modes
        '{'{6'd0,  6'd0,  6'd0,  6'd0,  MODE_BRES}, 1'b1, '{6'd0,  6'd0,  COLOUR_BRES, 1'b1}},
        '{'{6'd63, 6'd63, 6'd63, 6'd63, MODE_DDA},  1'b1, '{6'd63, 6'd63, COLOUR_DDA,  1'b1}},
        '{'{6'd42, 6'd21, 6'd42, 6'd21, MODE_BRES}, 1'b1, '{6'd42, 6'd21, COLOUR_BRES, 1'b1}},
        '{'{6'd21, 6'd42, 6'd21, 6'd42, MODE_DDA},  1'b1, '{6'd21, 6'd42, COLOUR_DDA,  1'b1}},
        // full-length axis and diagonal lines
        '{'{6'd0,  6'd0,  6'd63, 6'd0,  MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd63, 6'd63, 6'd0,  6'd63, MODE_DDA},  1'b0, '{default: '0}},
        '{'{6'd0,  6'd0,  6'd0,  6'd63, MODE_DDA},  1'b0, '{default: '0}},
        '{'{6'd63, 6'd63, 6'd63, 6'd0,  MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd0,  6'd0,  6'd63, 6'd63, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd63, 6'd0,  6'd0,  6'd63, MODE_DDA},  1'b0, '{default: '0}},
        // Bresenham in all eight octants around the center
        '{'{6'd32, 6'd32, 6'd50, 6'd40, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd40, 6'd50, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd24, 6'd50, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd14, 6'd40, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd14, 6'd24, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd24, 6'd14, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd40, 6'd14, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd50, 6'd24, MODE_BRES}, 1'b0, '{default: '0}},
        // DDA with inexact increments, rising and falling
        '{'{6'd32, 6'd32, 6'd13, 6'd27, MODE_DDA},  1'b0, '{default: '0}},
        '{'{6'd32, 6'd32, 6'd27, 6'd13, MODE_DDA},  1'b0, '{default: '0}},
        '{'{6'd10, 6'd5,  6'd53, 6'd62, MODE_DDA},  1'b0, '{default: '0}},
        '{'{6'd60, 6'd3,  6'd1,  6'd20, MODE_DDA},  1'b0, '{default: '0}},
        // alternating bit patterns
        '{'{6'd21, 6'd42, 6'd42, 6'd21, MODE_BRES}, 1'b0, '{default: '0}},
        '{'{6'd42, 6'd21, 6'd21, 6'd42, MODE_DDA},  1'b0, '{default: '0}}
    };

    line_rasterizer_bresenham_dda_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // Clock
    always
    begin
        #2 clk = ~clk;
    end

    // Gap before a transaction; now and then a stretch with no gaps at all
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Expand one request into the pixels it draws, appended to owed_pixels
    function automatic void rasterize_line(input req_t line);
        int   x0;
        int   y0;
        int   x1;
        int   y1;
        int   dx;
        int   dy;
        int   sx;
        int   sy;
        int   steps;
        int   maj;
        int   mnr;
        int   decision;
        int   x;
        int   y;
        bit   xmajor;
        logic [ACC_W-1:0] inc_x;
        logic [ACC_W-1:0] inc_y;
        pix_t p;

        x0 = line.start_x;
        y0 = line.start_y;
        x1 = line.end_x;
        y1 = line.end_y;
        dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
        sx = (x1 >= x0) ? 1 : -1;
        sy = (y1 >= y0) ? 1 : -1;
        steps = (dx >= dy) ? dx : dy;
        pixels_left = steps[6:0];
        dda_acc_x = ACC_W'(x0) << FRAC_BITS;
        dda_acc_y = ACC_W'(y0) << FRAC_BITS;

        if (line.mode == MODE_BRES)
        begin
            // Bresenham: major axis steps every pixel, minor on non-negative error
            xmajor = (dx >= dy);
            maj = xmajor ? dx : dy;
            mnr = xmajor ? dy : dx;
            decision = 2 * mnr - maj;
            x = x0;
            y = y0;
            p = '{COORD_W'(x), COORD_W'(y), COLOUR_BRES, steps == 0};
            owed_pixels.push_back(p);
            while (pixels_left > 0)
            begin
                if (decision >= 0)
                begin
                    decision += 2 * mnr - 2 * maj;
                    if (xmajor) y += sy;
                    else        x += sx;
                end
                else
                begin
                    decision += 2 * mnr;
                end
                if (xmajor) x += sx;
                else        y += sy;
                pixels_left--;
                p = '{COORD_W'(x), COORD_W'(y), COLOUR_BRES, pixels_left == 0};
                owed_pixels.push_back(p);
            end
        end
        else
        begin
            // DDA: truncated fixed-point increments, pixel is the integer part
            inc_x = '0;
            inc_y = '0;
            if (steps > 0)
            begin
                inc_x = ACC_W'((dx << FRAC_BITS) / steps);
                inc_y = ACC_W'((dy << FRAC_BITS) / steps);
            end
            p = '{dda_acc_x[ACC_W-1:FRAC_BITS], dda_acc_y[ACC_W-1:FRAC_BITS],
                  COLOUR_DDA, steps == 0};
            owed_pixels.push_back(p);
            while (pixels_left > 0)
            begin
                dda_acc_x = (sx > 0) ? dda_acc_x + inc_x : dda_acc_x - inc_x;
                dda_acc_y = (sy > 0) ? dda_acc_y + inc_y : dda_acc_y - inc_y;
                pixels_left--;
                p = '{dda_acc_x[ACC_W-1:FRAC_BITS], dda_acc_y[ACC_W-1:FRAC_BITS],
                      COLOUR_DDA, pixels_left == 0};
                owed_pixels.push_back(p);
            end
        end
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_line(input req_t line, input bit typed, input pix_t typed_pixel);
        int gap;

        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= line;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        if (typed)
            owed_pixels.push_back(typed_pixel);
        else
            rasterize_line(line);
    endtask

    // Random line: mostly arbitrary, some short, axis-aligned, diagonal or single-pixel
    function automatic req_t random_line();
        req_t line;
        int   kind;
        int   len;

        line.start_x = COORD_W'($urandom_range(0, 63));
        line.start_y = COORD_W'($urandom_range(0, 63));
        line.mode    = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 19);
        if (kind < 11)
        begin
            line.end_x = COORD_W'($urandom_range(0, 63));
            line.end_y = COORD_W'($urandom_range(0, 63));
        end
        else if (kind < 16)
        begin
            line.end_x = COORD_W'(int'(line.start_x) + $urandom_range(0, 8) - 4);
            line.end_y = COORD_W'(int'(line.start_y) + $urandom_range(0, 8) - 4);
            if (line.end_x > 6'd59 && line.start_x < 6'd4) line.end_x = line.start_x;
            if (line.end_y > 6'd59 && line.start_y < 6'd4) line.end_y = line.start_y;
            if (line.end_x < 6'd4 && line.start_x > 6'd59) line.end_x = line.start_x;
            if (line.end_y < 6'd4 && line.start_y > 6'd59) line.end_y = line.start_y;
        end
        else if (kind == 16)
        begin
            line.end_x = COORD_W'($urandom_range(0, 63));
            line.end_y = line.start_y;
        end
        else if (kind == 17)
        begin
            line.end_x = line.start_x;
            line.end_y = COORD_W'($urandom_range(0, 63));
        end
        else if (kind == 18)
        begin
            len = $urandom_range(0, 63);
            line.end_x = (line.start_x + len > 63) ? line.start_x - COORD_W'(len)
                                                   : line.start_x + COORD_W'(len);
            line.end_y = (line.start_y + len > 63) ? line.start_y - COORD_W'(len)
                                                   : line.start_y + COORD_W'(len);
        end
        else
        begin
            line.end_x = line.start_x;
            line.end_y = line.start_y;
        end
        return line;
    endfunction

    // Request side: reset, directed table, then random lines
    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        send_calm       = 0;
        stimulus_done   = 1'b0;
        long_hold_armed = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_line(directed_lines[i].line, directed_lines[i].typed,
                      directed_lines[i].pixel);

        // stall the pixel side for a long stretch while requests keep coming
        long_hold_armed = 1'b1;
        for (int i = 0; i < RANDOM_LINES; i++)
            send_line(random_line(), 1'b0, '0);
        req_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Pixel side: random stalls, check each transaction against the oldest owed
    initial
    begin
        int   gap;
        pix_t want;
        bit   long_hold_done;

        pix_ready      = 1'b0;
        take_calm      = 0;
        mismatch_count = 0;
        pixels_checked = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(take_calm);
            if (long_hold_armed && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                pix_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(pix_valid && pix_ready));
            if (owed_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %p", $time, pix);
                mismatch_count++;
            end
            else
            begin
                want = owed_pixels.pop_front();
                pixels_checked++;
                if (pix.pix_x !== want.pix_x)
                begin
                    $display("%0t: pix_x expected %0d actual %0d", $time, want.pix_x, pix.pix_x);
                    mismatch_count++;
                end
                if (pix.pix_y !== want.pix_y)
                begin
                    $display("%0t: pix_y expected %0d actual %0d", $time, want.pix_y, pix.pix_y);
                    mismatch_count++;
                end
                if (pix.colour !== want.colour)
                begin
                    $display("%0t: colour expected %0d actual %0d", $time, want.colour,
                             pix.colour);
                    mismatch_count++;
                end
                if (pix.last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, pix.last);
                    mismatch_count++;
                end
            end
        end
    end

    // End of run: everything sent, nothing owed, then a quiet drain
    initial
    begin
        wait (stimulus_done);
        while (owed_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** line_rasterizer_bresenham_dda_unit: PASSED **");
        else
            $display("** line_rasterizer_bresenham_dda_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d pixels checked, %0d still owed", $time, pixels_checked,
                 owed_pixels.size());
        $display("** line_rasterizer_bresenham_dda_unit: FAILED **");
        $finish;
    end

endmodule
